[src/qla_pkg.sv]
package qla_pkg;

	// fixed field widths
	localparam int STATE_IN_W = 8;
	localparam int ACTION_IN_W = 4;
	localparam int VALUE_W = 32;
	localparam int FRAC_W = 16;
	localparam int WORD_W = 16;
	localparam int COUNT_W = 5;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS_IN_USE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 4'd3;

	localparam logic [COUNT_W-1:0] RST_ACTIONS_IN_USE = 5'd16;
	localparam logic [FRAC_W-1:0] RST_LEARNING_RATE = 16'd6554;
	localparam logic [FRAC_W-1:0] RST_DISCOUNT_FACTOR = 16'd62259;
	localparam logic [FRAC_W-1:0] RST_EXPLORE_THRESHOLD = 16'd6554;

	// multiply-accumulate unit widths
	localparam int OPND_W = 35;
	localparam int SUM_W = 37;
	localparam int PROD_W = FRAC_W + 1 + OPND_W;

	localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

	// restoring remainder, one bit of the random word a step
	localparam int MOD_STEPS = WORD_W;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	typedef struct packed {
		logic go;
		logic [FRAC_W-1:0] coef;
		logic signed [OPND_W-1:0] operand;
		logic signed [SUM_W-1:0] addend;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [SUM_W-1:0] value;
	} alu_rsp_t;

endpackage

[src/qla_ram.sv]
module qla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/qla_alu.sv]
// result = addend + floor(coef * operand / 2^16), coef unsigned Q0.16
// registered in order: product register, then sum register
module qla_alu (
	input logic clk,
	input logic arst_n,
	input qla_pkg::alu_req_t req,
	output qla_pkg::alu_rsp_t rsp
);

	logic vld_s1;
	logic done_s2;
	logic signed [qla_pkg::PROD_W-1:0] prod_s1;
	logic signed [qla_pkg::SUM_W-1:0] addend_s1;
	logic signed [qla_pkg::SUM_W-1:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.go;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			prod_s1 <= $signed({1'b0, req.coef}) * req.operand;
			addend_s1 <= req.addend;
		end
		// dropping the low bits of a signed product floors it
		sum_s2 <= addend_s1 +
			qla_pkg::SUM_W'($signed(prod_s1[qla_pkg::PROD_W-1:qla_pkg::FRAC_W]));
	end

	assign rsp.done = done_s2;
	assign rsp.value = sum_s2;

endmodule

[src/tabular_q_learning_agent_unit.sv]
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    req_type .. random_pick
// out      out        out_valid/out_ready  chosen_action .. saturated
//
// One request at a time; the row scan reads one table entry per cycle from the
// single RAM read port. Exploit select scans the row; explore select reduces random_pick
// mod the active count; update scans, reads the old entry and passes twice through the shared MAC.
// After reset a clearing pass writes zero to all 2^(clog2(NUM_STATES)+clog2(NUM_ACTIONS))
// entries, one per cycle, with in_ready low; cfg writes are taken throughout.
// A finished result waits in the output register; the next request is accepted meanwhile.
module tabular_q_learning_agent_unit #(
	parameter int NUM_STATES = 256,
	parameter int NUM_ACTIONS = 16
) (
	input logic clk,
	input logic arst_n,

	input logic cfg_valid,
	output logic cfg_ready,
	input logic [qla_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [qla_pkg::CFG_DATA_W-1:0] cfg_data,

	input logic in_valid,
	output logic in_ready,
	input logic req_type,
	input logic [qla_pkg::STATE_IN_W-1:0] state_index,
	input logic [qla_pkg::ACTION_IN_W-1:0] action_index,
	input logic signed [qla_pkg::VALUE_W-1:0] reward,
	input logic [qla_pkg::STATE_IN_W-1:0] next_state_index,
	input logic [qla_pkg::WORD_W-1:0] explore_draw,
	input logic [qla_pkg::WORD_W-1:0] random_pick,

	output logic out_valid,
	input logic out_ready,
	output logic [qla_pkg::ACTION_IN_W-1:0] chosen_action,
	output logic explored,
	output logic signed [qla_pkg::VALUE_W-1:0] new_value,
	output logic saturated
);

	localparam int S_W = $clog2(NUM_STATES);
	localparam int A_W = $clog2(NUM_ACTIONS);
	localparam int ADDR_W = S_W + A_W;
	localparam int DEPTH = 2 ** ADDR_W;
	localparam int STATE_CODES = 2 ** qla_pkg::STATE_IN_W;
	localparam int ACTION_CODES = 2 ** qla_pkg::ACTION_IN_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OLD,
		ST_MUL1,
		ST_WAIT1,
		ST_MUL2,
		ST_WAIT2,
		ST_MOD,
		ST_FINISH
	} state_t;

	state_t state_q;

	// config registers
	logic [qla_pkg::COUNT_W-1:0] actions_q;
	logic [qla_pkg::FRAC_W-1:0] alpha_q;
	logic [qla_pkg::FRAC_W-1:0] gamma_q;
	logic [qla_pkg::FRAC_W-1:0] eps_q;
	logic [qla_pkg::COUNT_W-1:0] n_eff;

	// index reduction tables
	logic [S_W-1:0] row_tab [STATE_CODES];
	logic [A_W-1:0] col_tab [ACTION_CODES];

	// request registers
	logic upd_q;
	logic expl_q;
	logic [S_W-1:0] row_q;
	logic [S_W-1:0] scan_row_q;
	logic [A_W-1:0] act_q;
	logic signed [qla_pkg::VALUE_W-1:0] reward_q;
	logic [qla_pkg::WORD_W-1:0] pick_q;
	logic [qla_pkg::COUNT_W-1:0] n_q;

	// scan and arithmetic
	logic [A_W-1:0] col_q;
	logic iss_q;
	logic [A_W-1:0] iss_col_q;
	logic scan_last;
	logic signed [qla_pkg::VALUE_W-1:0] best_val_q;
	logic [A_W-1:0] best_col_q;
	logic signed [qla_pkg::VALUE_W-1:0] old_q;
	logic signed [qla_pkg::SUM_W-1:0] addend_q;
	logic signed [qla_pkg::OPND_W-1:0] delta_q;
	logic signed [qla_pkg::VALUE_W-1:0] nv_q;
	logic sat_q;
	logic signed [qla_pkg::VALUE_W-1:0] nv_sat;
	logic nv_clamped;

	logic [qla_pkg::COUNT_W-1:0] rem_q;
	logic [qla_pkg::COUNT_W-1:0] rem_next;
	logic [qla_pkg::COUNT_W:0] mod_trial;
	logic [qla_pkg::MOD_CNT_W-1:0] mod_cnt_q;

	logic [ADDR_W-1:0] clr_addr_q;

	// RAM
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [qla_pkg::VALUE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [qla_pkg::VALUE_W-1:0] ram_rdata;
	logic signed [qla_pkg::VALUE_W-1:0] rd_data;

	qla_pkg::alu_req_t alu_req;
	qla_pkg::alu_rsp_t alu_rsp;

	logic accept;
	logic out_free;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	for (genvar g = 0; g < STATE_CODES; g++) begin : g_row_tab
		assign row_tab[g] = S_W'(g % NUM_STATES);
	end
	for (genvar g = 0; g < ACTION_CODES; g++) begin : g_col_tab
		assign col_tab[g] = A_W'(g % NUM_ACTIONS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			actions_q <= qla_pkg::RST_ACTIONS_IN_USE;
			alpha_q <= qla_pkg::RST_LEARNING_RATE;
			gamma_q <= qla_pkg::RST_DISCOUNT_FACTOR;
			eps_q <= qla_pkg::RST_EXPLORE_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qla_pkg::CFG_ACTIONS_IN_USE: actions_q <= cfg_data[qla_pkg::COUNT_W-1:0];
				qla_pkg::CFG_LEARNING_RATE: alpha_q <= cfg_data;
				qla_pkg::CFG_DISCOUNT_FACTOR: gamma_q <= cfg_data;
				qla_pkg::CFG_EXPLORE_THRESHOLD: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (actions_q == '0) begin
			n_eff = qla_pkg::COUNT_W'(1);
		end else if (32'(actions_q) > 32'(NUM_ACTIONS)) begin
			n_eff = qla_pkg::COUNT_W'(NUM_ACTIONS);
		end else begin
			n_eff = actions_q;
		end
	end

	assign scan_last = (32'(col_q) + 32'd1) == 32'(n_q);

	assign mod_trial = {rem_q, pick_q[qla_pkg::WORD_W-1]};
	always_comb begin
		if (mod_trial >= {1'b0, n_q}) begin
			rem_next = qla_pkg::COUNT_W'(mod_trial - {1'b0, n_q});
		end else begin
			rem_next = mod_trial[qla_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		nv_clamped = 1'b1;
		priority if (alu_rsp.value > qla_pkg::SUM_W'(qla_pkg::Q_MAX)) begin
			nv_sat = qla_pkg::Q_MAX;
		end else if (alu_rsp.value < qla_pkg::SUM_W'(qla_pkg::Q_MIN)) begin
			nv_sat = qla_pkg::Q_MIN;
		end else begin
			nv_sat = alu_rsp.value[qla_pkg::VALUE_W-1:0];
			nv_clamped = 1'b0;
		end
	end

	// shared MAC: delta = (reward - old) + gamma*max, then new = old + alpha*delta
	always_comb begin
		alu_req.go = (state_q == ST_MUL1) || (state_q == ST_MUL2);
		if (state_q == ST_MUL1) begin
			alu_req.coef = gamma_q;
			alu_req.operand = qla_pkg::OPND_W'(best_val_q);
			alu_req.addend = addend_q;
		end else begin
			alu_req.coef = alpha_q;
			alu_req.operand = delta_q;
			alu_req.addend = qla_pkg::SUM_W'(old_q);
		end
	end

	qla_alu u_alu (
		.clk (clk),
		.arst_n (arst_n),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we = (state_q == ST_WAIT2) && alu_rsp.done;
			ram_waddr = {row_q, act_q};
			ram_wdata = nv_sat;
		end
		// outside the scan the port reads the entry that the update rewrites
		ram_raddr = (state_q == ST_SCAN) ? {scan_row_q, col_q} : {row_q, act_q};
	end

	qla_ram #(
		.WIDTH (qla_pkg::VALUE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk (clk),
		.we (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_data = $signed(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			col_q <= '0;
			mod_cnt_q <= '0;
			iss_q <= 1'b0;
			out_valid_q <= 1'b0;
			chosen_action <= '0;
			explored <= 1'b0;
			new_value <= '0;
			saturated <= 1'b0;
		end else begin
			iss_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						col_q <= '0;
						mod_cnt_q <= '0;
						if (!req_type && (explore_draw < eps_q)) begin
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					iss_q <= 1'b1;
					if (scan_last) begin
						col_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= upd_q ? ST_OLD : ST_FINISH;
				ST_OLD: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (alu_rsp.done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (alu_rsp.done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q + 1'b1;
					if (mod_cnt_q == qla_pkg::MOD_CNT_W'(qla_pkg::MOD_STEPS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (upd_q) begin
							chosen_action <= '0;
							explored <= 1'b0;
							new_value <= nv_q;
							saturated <= sat_q;
						end else begin
							chosen_action <= expl_q ? qla_pkg::ACTION_IN_W'(rem_q)
								: qla_pkg::ACTION_IN_W'(best_col_q);
							explored <= expl_q;
							new_value <= '0;
							saturated <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		iss_col_q <= col_q;
		if (accept) begin
			upd_q <= req_type;
			expl_q <= !req_type && (explore_draw < eps_q);
			row_q <= row_tab[state_index];
			scan_row_q <= req_type ? row_tab[next_state_index] : row_tab[state_index];
			act_q <= col_tab[action_index];
			reward_q <= reward;
			pick_q <= random_pick;
			n_q <= n_eff;
			rem_q <= '0;
		end
		// strict compare keeps the lowest column on ties
		if (iss_q && ((iss_col_q == '0) || (rd_data > best_val_q))) begin
			best_val_q <= rd_data;
			best_col_q <= iss_col_q;
		end
		if (state_q == ST_OLD) begin
			old_q <= rd_data;
			addend_q <= qla_pkg::SUM_W'(reward_q) - qla_pkg::SUM_W'(rd_data);
		end
		if ((state_q == ST_WAIT1) && alu_rsp.done) begin
			delta_q <= qla_pkg::OPND_W'(alu_rsp.value);
		end
		if ((state_q == ST_WAIT2) && alu_rsp.done) begin
			nv_q <= nv_sat;
			sat_q <= nv_clamped;
		end
		if (state_q == ST_MOD) begin
			rem_q <= rem_next;
			pick_q <= pick_q << 1;
		end
	end

endmodule

[src/qla_check.sv]
module qla_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [qla_pkg::ACTION_IN_W-1:0] chosen_action,
	input logic explored,
	input logic signed [qla_pkg::VALUE_W-1:0] new_value,
	input logic saturated
);

	// one request in flight: no accept in the cycle after one
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(new_value)
			&& $stable(chosen_action)))
		else $error("stalled result changed");

	a_explore_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && explored) |-> (new_value == '0 && !saturated))
		else $error("exploration result carries update fields");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> ((new_value == qla_pkg::Q_MAX
			|| new_value == qla_pkg::Q_MIN) && chosen_action == '0 && !explored))
		else $error("saturated flag without clamped value");

endmodule

bind tabular_q_learning_agent_unit qla_check u_qla_check (.*);

[tb/qla_tb_pkg.sv]
`timescale 1ns / 1ps
package qla_tb_pkg;

	typedef enum logic {
		REQ_SELECT = 1'b0,
		REQ_UPDATE = 1'b1
	} req_kind_e;

	// indexes from here up to the top of the index range map to no register
	localparam logic [qla_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = qla_pkg::CFG_EXPLORE_THRESHOLD + 1'b1;

	typedef struct packed {
		req_kind_e kind;
		logic [qla_pkg::STATE_IN_W-1:0] state;
		logic [qla_pkg::ACTION_IN_W-1:0] action;
		logic signed [qla_pkg::VALUE_W-1:0] reward;
		logic [qla_pkg::STATE_IN_W-1:0] succ_state;
		logic [qla_pkg::WORD_W-1:0] draw;
		logic [qla_pkg::WORD_W-1:0] pick;
	} agent_request_t;

	typedef struct packed {
		logic [qla_pkg::ACTION_IN_W-1:0] action;
		logic explored;
		logic signed [qla_pkg::VALUE_W-1:0] value;
		logic saturated;
	} agent_result_t;

endpackage

[tb/qla_result_checker.sv]
`timescale 1ns / 1ps
module qla_result_checker (
	input logic clk,
	input logic arst_n,

	input logic cfg_valid,
	input logic cfg_ready,
	input logic [qla_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [qla_pkg::CFG_DATA_W-1:0] cfg_data,

	input logic in_valid,
	input logic in_ready,
	input logic req_type,
	input logic [qla_pkg::STATE_IN_W-1:0] state_index,
	input logic [qla_pkg::ACTION_IN_W-1:0] action_index,
	input logic signed [qla_pkg::VALUE_W-1:0] reward,
	input logic [qla_pkg::STATE_IN_W-1:0] next_state_index,
	input logic [qla_pkg::WORD_W-1:0] explore_draw,
	input logic [qla_pkg::WORD_W-1:0] random_pick,

	input logic out_valid,
	input logic out_ready,
	input logic [qla_pkg::ACTION_IN_W-1:0] chosen_action,
	input logic explored,
	input logic signed [qla_pkg::VALUE_W-1:0] new_value,
	input logic saturated,

	output int mismatch_count,
	output int results_owed
);
	import qla_pkg::*;
	import qla_tb_pkg::*;

	localparam int TABLE_COLS = 16;
	localparam int TABLE_ENTRIES = 256 * TABLE_COLS;

	logic signed [VALUE_W-1:0] q_table [0:TABLE_ENTRIES-1];
	logic [COUNT_W-1:0] act_count;
	logic [FRAC_W-1:0] alpha;
	logic [FRAC_W-1:0] gamma;
	logic [FRAC_W-1:0] epsilon;
	agent_result_t pending_q [$];

	function automatic agent_result_t predict_request(input agent_request_t r);
		agent_result_t e;
		int unsigned n;
		logic signed [VALUE_W-1:0] best_q;
		longint signed old_q, row_max, delta, nv;
		e = '0;
		n = (act_count == 0) ? 1 : ((act_count > TABLE_COLS) ? TABLE_COLS : act_count);
		if (r.kind == REQ_SELECT) begin
			if (r.draw < epsilon) begin
				e.action = ACTION_IN_W'(r.pick % n);
				e.explored = 1'b1;
			end else begin
				best_q = q_table[{r.state, 4'd0}];
				for (int a = 1; a < n; a++) begin
					// strict compare keeps the lowest index on ties
					if (q_table[{r.state, 4'(a)}] > best_q) begin
						best_q = q_table[{r.state, 4'(a)}];
						e.action = 4'(a);
					end
				end
			end
		end else begin
			// row maximum is read before the write, so next == current sees the old value
			old_q = q_table[{r.state, r.action}];
			row_max = q_table[{r.succ_state, 4'd0}];
			for (int a = 1; a < n; a++) begin
				if (q_table[{r.succ_state, 4'(a)}] > row_max)
					row_max = q_table[{r.succ_state, 4'(a)}];
			end
			delta = longint'(r.reward) + ((longint'(gamma) * row_max) >>> FRAC_W) - old_q;
			nv = old_q + ((longint'(alpha) * delta) >>> FRAC_W);
			if (nv > longint'(Q_MAX)) begin
				nv = longint'(Q_MAX);
				e.saturated = 1'b1;
			end else if (nv < longint'(Q_MIN)) begin
				nv = longint'(Q_MIN);
				e.saturated = 1'b1;
			end
			q_table[{r.state, r.action}] = nv[VALUE_W-1:0];
			e.value = nv[VALUE_W-1:0];
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int errs;
		agent_result_t want;
		agent_request_t req;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				q_table[i] = '0;
			act_count = RST_ACTIONS_IN_USE;
			alpha = RST_LEARNING_RATE;
			gamma = RST_DISCOUNT_FACTOR;
			epsilon = RST_EXPLORE_THRESHOLD;
			pending_q.delete();
			mismatch_count <= 0;
			results_owed <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ACTIONS_IN_USE: act_count = cfg_data[COUNT_W-1:0];
					CFG_LEARNING_RATE: alpha = cfg_data;
					CFG_DISCOUNT_FACTOR: gamma = cfg_data;
					CFG_EXPLORE_THRESHOLD: epsilon = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: result with no request pending: action %0d explored %0b value %0d sat %0b",
						$time, chosen_action, explored, new_value, saturated);
					errs++;
				end else begin
					want = pending_q.pop_front();
					if (chosen_action !== want.action) begin
						$display("%0t: chosen_action expected %0d got %0d", $time, want.action, chosen_action);
						errs++;
					end
					if (explored !== want.explored) begin
						$display("%0t: explored expected %0b got %0b", $time, want.explored, explored);
						errs++;
					end
					if (new_value !== want.value) begin
						$display("%0t: new_value expected %0d got %0d", $time, $signed(want.value), new_value);
						errs++;
					end
					if (saturated !== want.saturated) begin
						$display("%0t: saturated expected %0b got %0b", $time, want.saturated, saturated);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				req.kind = req_kind_e'(req_type);
				req.state = state_index;
				req.action = action_index;
				req.reward = reward;
				req.succ_state = next_state_index;
				req.draw = explore_draw;
				req.pick = random_pick;
				pending_q.push_back(predict_request(req));
			end
			mismatch_count <= mismatch_count + errs;
			results_owed <= pending_q.size();
		end
	end

endmodule

[tb/tabular_q_learning_agent_unit_tb.sv]
`timescale 1ns / 1ps
module tabular_q_learning_agent_unit_tb;
	import qla_pkg::*;
	import qla_tb_pkg::*;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_PER_PHASE = 170;
	localparam int BURST_ITEMS = 24;
	localparam int LONG_STALL = 300;
	localparam int DRAIN_CYCLES = 60;
	// clearing pass after reset writes all 4096 entries with nothing accepted
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;

	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [STATE_IN_W-1:0] state_index;
	logic [ACTION_IN_W-1:0] action_index;
	logic signed [VALUE_W-1:0] reward;
	logic [STATE_IN_W-1:0] next_state_index;
	logic [WORD_W-1:0] explore_draw;
	logic [WORD_W-1:0] random_pick;

	logic out_valid;
	logic out_ready;
	logic [ACTION_IN_W-1:0] chosen_action;
	logic explored;
	logic signed [VALUE_W-1:0] new_value;
	logic saturated;

	int mismatch_count;
	int results_owed;
	int send_idle_pct;
	int recv_stall_pct;
	int stall_orders;
	int stalls_taken;
	int stall_left;
	int quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tabular_q_learning_agent_unit u_dut (.*);

	qla_result_checker u_checker (.*);

	// result side: random stalls, plus a long hold-off each time one is ordered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stalls_taken <= 0;
			stall_left <= 0;
		end else if (stall_orders != stalls_taken) begin
			stalls_taken <= stall_orders;
			stall_left <= LONG_STALL;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic agent_request_t make_req(input req_kind_e kind, input int st, input int act,
			input logic signed [VALUE_W-1:0] rwd, input int nxt, input int draw, input int pick);
		agent_request_t r;
		r.kind = kind;
		r.state = STATE_IN_W'(st);
		r.action = ACTION_IN_W'(act);
		r.reward = rwd;
		r.succ_state = STATE_IN_W'(nxt);
		r.draw = WORD_W'(draw);
		r.pick = WORD_W'(pick);
		return r;
	endfunction

	// most traffic hits a few hot states so rows fill up and maxima matter
	function automatic agent_request_t random_req();
		agent_request_t r;
		r.kind = ($urandom_range(99) < 60) ? REQ_UPDATE : REQ_SELECT;
		r.state = ($urandom_range(9) < 8) ? STATE_IN_W'($urandom_range(0, 7)) : STATE_IN_W'($urandom());
		case ($urandom_range(3))
			0: r.succ_state = r.state;
			1: r.succ_state = STATE_IN_W'($urandom());
			default: r.succ_state = STATE_IN_W'($urandom_range(0, 7));
		endcase
		r.action = ACTION_IN_W'($urandom());
		case ($urandom_range(9))
			0: r.reward = Q_MAX;
			1: r.reward = Q_MIN;
			2, 3: r.reward = $urandom();
			default: r.reward = $signed($urandom_range(0, 20 << FRAC_W)) - (10 <<< FRAC_W);
		endcase
		r.draw = WORD_W'($urandom());
		r.pick = WORD_W'($urandom());
		return r;
	endfunction

	function automatic logic [FRAC_W-1:0] random_fraction();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return FRAC_W'($urandom());
		endcase
	endfunction

	task automatic put_request(input agent_request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		state_index <= r.state;
		action_index <= r.action;
		reward <= r.reward;
		next_state_index <= r.succ_state;
		explore_draw <= r.draw;
		random_pick <= r.pick;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_config();
		logic [COUNT_W-1:0] n;
		case ($urandom_range(7))
			0: n = 5'd0;
			1: n = 5'd1;
			2: n = 5'd16;
			3: n = 5'd31;
			default: n = COUNT_W'($urandom_range(1, 16));
		endcase
		// upper data bits are don't-care for the action count
		write_reg(CFG_ACTIONS_IN_USE, {11'($urandom()), n});
		write_reg(CFG_LEARNING_RATE, random_fraction());
		write_reg(CFG_DISCOUNT_FACTOR, random_fraction());
		write_reg(CFG_EXPLORE_THRESHOLD, random_fraction());
		write_reg(CFG_IDX_W'($urandom_range(int'(CFG_UNMAPPED), (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom()));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_SELECT;
		state_index = '0;
		action_index = '0;
		reward = '0;
		next_state_index = '0;
		explore_draw = '0;
		random_pick = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_orders = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ties, explore bounds, same-state update, top state
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, 16'hFFFF, 0));
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, 0, 16'hFFFF));
		put_request(make_req(REQ_UPDATE, 0, 15, Q_MAX, 255, 0, 0));
		put_request(make_req(REQ_UPDATE, 0, 3, Q_MIN, 0, 16'hFFFF, 16'hFFFF));
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, 16'hFFFF, 0));
		put_request(make_req(REQ_UPDATE, 5, 2, 32'sh0001_0000, 5, 0, 0));
		put_request(make_req(REQ_UPDATE, 255, 15, 32'sh1234_5678, 0, 0, 0));
		put_request(make_req(REQ_SELECT, 255, 0, 0, 0, 16'hFFFF, 0));
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, RST_EXPLORE_THRESHOLD - 1, 16'h1234));
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, RST_EXPLORE_THRESHOLD, 16'h1234));
		drain_results();

		// full-scale alpha and gamma drive the entry into positive clamping
		write_reg(CFG_LEARNING_RATE, 16'hFFFF);
		write_reg(CFG_DISCOUNT_FACTOR, 16'hFFFF);
		write_reg(CFG_EXPLORE_THRESHOLD, 16'h0000);
		repeat (3) put_request(make_req(REQ_UPDATE, 1, 0, Q_MAX, 1, 0, 0));
		put_request(make_req(REQ_SELECT, 1, 0, 0, 0, 0, 0));
		drain_results();

		// one active column: row max is the entry itself, so it clamps negative
		write_reg(CFG_ACTIONS_IN_USE, 16'd1);
		write_reg(CFG_EXPLORE_THRESHOLD, 16'hFFFF);
		repeat (3) put_request(make_req(REQ_UPDATE, 2, 0, Q_MIN, 2, 0, 0));
		put_request(make_req(REQ_SELECT, 2, 0, 0, 0, 0, 16'hFFFF));
		put_request(make_req(REQ_SELECT, 2, 0, 0, 0, 16'hFFFF, 0));
		drain_results();

		// zero count acts as one; unmapped index must change nothing
		write_reg(CFG_ACTIONS_IN_USE, 16'd0);
		write_reg(CFG_UNMAPPED, 16'hFFFF);
		write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 16'hFFFF);
		put_request(make_req(REQ_SELECT, 2, 0, 0, 0, 0, 16'hFFFF));
		drain_results();

		// count above table width, alpha and gamma zero
		write_reg(CFG_ACTIONS_IN_USE, 16'd31);
		write_reg(CFG_LEARNING_RATE, 16'h0000);
		write_reg(CFG_DISCOUNT_FACTOR, 16'h0000);
		write_reg(CFG_EXPLORE_THRESHOLD, 16'h0000);
		put_request(make_req(REQ_UPDATE, 3, 9, Q_MAX, 0, 0, 0));
		put_request(make_req(REQ_SELECT, 0, 0, 0, 0, 0, 0));
		drain_results();

		// write to a column past the active count; it must not enter the row max
		write_reg(CFG_ACTIONS_IN_USE, 16'd4);
		write_reg(CFG_LEARNING_RATE, 16'h8000);
		put_request(make_req(REQ_UPDATE, 4, 12, 32'sh0005_0000, 4, 0, 0));
		put_request(make_req(REQ_SELECT, 4, 0, 0, 0, 16'hFFFF, 0));
		put_request(make_req(REQ_UPDATE, 4, 0, -32'sh0003_0000, 4, 0, 0));
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			random_config();
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				put_request(random_req());
			drain_results();
			if (phase == 0) begin
				// receiver holds off while requests keep coming, so the input backs up
				stall_orders <= stall_orders + 1;
				for (int i = 0; i < BURST_ITEMS; i++)
					put_request(random_req());
				drain_results();
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
src/qla_pkg.sv
src/qla_ram.sv
src/qla_alu.sv
src/tabular_q_learning_agent_unit.sv
src/qla_check.sv
tb/qla_tb_pkg.sv
tb/qla_result_checker.sv
tb/tabular_q_learning_agent_unit_tb.sv
